FILE: hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on clk, off during reset.
`define ARLC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion on clk, checked during reset as well.
`define ARLC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/arlc_pkg.sv
package arlc_pkg;

  localparam int unsigned BUFFER_BYTES_DEF = 1024;
  localparam int unsigned PATTERN_COUNT    = 4;
  localparam int unsigned POS_W            = 4;
  localparam logic [POS_W-1:0] POS_MAX     = '1;
  localparam logic [7:0] NEWLINE           = 8'h0A;
  localparam logic [PATTERN_COUNT-1:0] ALL_FLAGS = '1;

  localparam logic OP_BYTE    = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  typedef enum logic [1:0] {
    REPLY_OK    = 2'd0,
    REPLY_ERROR = 2'd1,
    REPLY_BUSY  = 2'd2,
    REPLY_READY = 2'd3
  } reply_t;

  typedef logic [POS_W-1:0] pos_t;
  typedef logic [PATTERN_COUNT-1:0] flags_t;

  typedef struct packed {
    flags_t flags;
    logic   hit;
    reply_t code;
  } match_t;

  localparam pos_t PATTERN_LEN [PATTERN_COUNT] = '{4'd4, 4'd7, 4'd11, 4'd7};

  function automatic logic [7:0] pattern_char(input logic [1:0] k, input pos_t pos);
    logic [7:0] c;
    c = 8'h00;
    case (k)
      2'd0: begin
        case (pos)
          4'd0: c = "O";
          4'd1: c = "K";
          4'd2: c = 8'h0D;
          4'd3: c = 8'h0A;
          default: c = 8'h00;
        endcase
      end
      2'd1: begin
        case (pos)
          4'd0: c = "E";
          4'd1: c = "R";
          4'd2: c = "R";
          4'd3: c = "O";
          4'd4: c = "R";
          4'd5: c = 8'h0D;
          4'd6: c = 8'h0A;
          default: c = 8'h00;
        endcase
      end
      2'd2: begin
        case (pos)
          4'd0: c = "b";
          4'd1: c = "u";
          4'd2: c = "s";
          4'd3: c = "y";
          4'd4: c = " ";
          4'd5: c = "p";
          4'd6: c = ".";
          4'd7: c = ".";
          4'd8: c = ".";
          4'd9: c = 8'h0D;
          4'd10: c = 8'h0A;
          default: c = 8'h00;
        endcase
      end
      default: begin
        case (pos)
          4'd0: c = "r";
          4'd1: c = "e";
          4'd2: c = "a";
          4'd3: c = "d";
          4'd4: c = "y";
          4'd5: c = 8'h0D;
          4'd6: c = 8'h0A;
          default: c = 8'h00;
        endcase
      end
    endcase
    return c;
  endfunction

endpackage

FILE: hdl/arlc_match.sv
module arlc_match
  import arlc_pkg::*;
(
  input  flags_t     flags,
  input  pos_t       pos,
  input  logic [7:0] rx_byte,
  output match_t     result
);

  flags_t next_flags;
  flags_t ends;

  always_comb begin
    for (int k = 0; k < PATTERN_COUNT; k++) begin
      next_flags[k] = flags[k] && (pos < PATTERN_LEN[k]) &&
                      (pattern_char(2'(k), pos) == rx_byte);
      ends[k] = next_flags[k] && ((pos + 4'd1) == PATTERN_LEN[k]);
    end
  end

  always_comb begin
    result.flags = next_flags;
    result.hit   = (rx_byte == NEWLINE) && (ends != '0);
    if (ends[0]) begin
      result.code = REPLY_OK;
    end else if (ends[1]) begin
      result.code = REPLY_ERROR;
    end else if (ends[2]) begin
      result.code = REPLY_BUSY;
    end else begin
      result.code = REPLY_READY;
    end
  end

endmodule

FILE: hdl/at_response_line_classifier.sv
// Recognizes AT modem reply lines ("OK", "ERROR", "busy p...", "ready", each
// ended by CR LF) in a received byte stream, one request per clock while
// in_stall is low. A byte request (opcode 0) is compared against all four
// patterns at once; when a newline closes a line that equals a pattern, one
// reply_code comes out on the next cycle through the output register. A
// restart request (opcode 1) begins a new capture; reset acts as a restart.
// At most BUFFER_BYTES - 1 bytes are taken per capture, later bytes are
// dropped until a restart. in_stall is high only while a result waits in the
// output register and the downstream side stalls.
module at_response_line_classifier
  import arlc_pkg::*;
#(
  parameter int unsigned BUFFER_BYTES = BUFFER_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       opcode,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] reply_code
);

  localparam int unsigned CNT_W = $clog2(BUFFER_BYTES);
  localparam logic [CNT_W-1:0] LIMIT = CNT_W'(BUFFER_BYTES - 1);

  logic [CNT_W-1:0] stored_count;
  pos_t             line_position;
  flags_t           candidate_flags;
  match_t           match;
  logic             accept;
  logic             byte_take;

  arlc_match u_match (
    .flags   (candidate_flags),
    .pos     (line_position),
    .rx_byte (rx_byte),
    .result  (match)
  );

  assign in_stall  = out_valid && out_stall;
  assign accept    = in_valid && !in_stall;
  assign byte_take = accept && (opcode == OP_BYTE) && (stored_count != LIMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      stored_count    <= '0;
      line_position   <= '0;
      candidate_flags <= ALL_FLAGS;
    end else if (accept && (opcode == OP_RESTART)) begin
      stored_count    <= '0;
      line_position   <= '0;
      candidate_flags <= ALL_FLAGS;
    end else if (byte_take) begin
      stored_count <= stored_count + 1'b1;
      if (rx_byte == NEWLINE) begin
        line_position   <= '0;
        candidate_flags <= ALL_FLAGS;
      end else begin
        candidate_flags <= match.flags;
        if (line_position != POS_MAX) begin
          line_position <= line_position + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!in_stall) begin
      out_valid <= byte_take && match.hit;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && byte_take && match.hit) begin
      reply_code <= match.code;
    end
  end

endmodule

FILE: hdl/arlc_checker.sv
`include "assert_macros.svh"

module arlc_checker
  import arlc_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       opcode,
  input logic [7:0] rx_byte,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] reply_code
);

  logic req_restart;
  logic req_no_nl;

  assign req_restart = in_valid && !in_stall && (opcode == OP_RESTART);
  assign req_no_nl   = in_valid && !in_stall && (rx_byte != NEWLINE);

  `ARLC_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "result dropped while stalled")
  `ARLC_ASSERT(a_code_hold, out_valid && out_stall |=> $stable(reply_code), "reply changed")
  `ARLC_ASSERT_ALWAYS(a_stall_only_full, in_stall |-> out_valid && out_stall, "needless stall")
  `ARLC_ASSERT(a_restart_silent, !out_valid && req_restart |=> !out_valid, "result from restart")
  `ARLC_ASSERT(a_newline_only, !out_valid && req_no_nl |=> !out_valid, "result without newline")

endmodule

bind at_response_line_classifier arlc_checker u_arlc_checker (.*);
